@@ src/lzhc_pkg.sv @@
// Package for the LZ77 hash-chain match finder: sizes, opcodes, register
// indexes and the controller state type. No dependencies.
package lzhc_pkg;

  localparam int BUF_SIZE  = 4096;
  localparam int BUF_AW    = 12;
  localparam int HASH_SIZE = 8192;
  localparam int HASH_AW   = 13;
  localparam int LEN_W     = 13;
  localparam int CAP_W     = 14;
  localparam int MAX_MATCH = 255;

  typedef enum logic [1:0] {
    OP_WR_DICT = 2'd0,
    OP_WR_TGT  = 2'd1,
    OP_INSERT  = 2'd2,
    OP_FIND    = 2'd3
  } op_t;

  localparam logic [1:0] CFG_DICT_LEN = 2'd0;
  localparam logic [1:0] CFG_TGT_LEN  = 2'd1;
  localparam logic [1:0] CFG_HASH_CAP = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY,
    ST_DIV,
    ST_HEAD_RD,
    ST_HEAD_WAIT,
    ST_CAND,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_EVAL,
    ST_LINK_WAIT,
    ST_DONE
  } state_t;

endpackage

@@ src/lzhc_if.sv @@
// Handshake interfaces for the input, result and configuration channels.
// Depends on lzhc_pkg for the field widths.
interface lzhc_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [lzhc_pkg::BUF_AW-1:0] position;
  logic [7:0]                  data_byte;
  logic                        target_in_dict;
  modport source (output valid, opcode, position, data_byte, target_in_dict, input ready);
  modport sink (input valid, opcode, position, data_byte, target_in_dict, output ready);
endinterface

interface lzhc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lzhc_pkg::BUF_AW-1:0] match_position;
  logic [7:0]                  match_length;
  modport source (output valid, match_position, match_length, input ready);
  modport sink (input valid, match_position, match_length, output ready);
endinterface

interface lzhc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 idx;
  logic [lzhc_pkg::CAP_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

@@ src/lz_hash_chain_match_finder_top.sv @@
// LZ77 hash-chain match finder, top level. Depends on lzhc_pkg, lzhc_if, lzhc_ram.
// An insert reads four key bytes, runs a bit-serial modulo and a head read-modify-write.
// A find does the same key work, then per chain candidate a setup step, a read and
// check per compared byte, one more read if the compare hits its limit, an evaluate
// and a link read. After reset the head and link tables are cleared, one entry per
// cycle; no item is taken meanwhile, configuration writes are.
module lz_hash_chain_match_finder_top (
  input  logic        clk,
  input  logic        rst_n,
  lzhc_in_if.sink     in_if,
  lzhc_out_if.source  out_if,
  lzhc_cfg_if.sink    cfg_if
);
  import lzhc_pkg::*;

  state_t                 state_r, state_nxt;
  logic [HASH_AW-1:0]     clr_r, clr_nxt;
  logic [LEN_W-1:0]       dict_len_r, tgt_len_r;
  logic [CAP_W-1:0]       cap_r;
  logic                   is_find_r, is_find_nxt;
  logic [BUF_AW-1:0]      pos_r, pos_nxt;
  logic                   in_dict_r, in_dict_nxt;
  logic [2:0]             kcnt_r, kcnt_nxt;
  logic                   oob_r, oob_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [CAP_W-1:0]       rem_r, rem_nxt;
  logic [4:0]             dcnt_r, dcnt_nxt;
  logic [HASH_AW-1:0]     entry_r, entry_nxt;
  logic [HASH_AW-1:0]     steps_r, steps_nxt;
  logic [BUF_AW-1:0]      cand_r, cand_nxt;
  logic [7:0]             lim_r, lim_nxt;
  logic [7:0]             cnt_r, cnt_nxt;
  logic [BUF_AW-1:0]      best_pos_r, best_pos_nxt;
  logic [7:0]             best_len_r, best_len_nxt;
  logic [BUF_AW-1:0]      res_pos_r, res_pos_nxt;
  logic [7:0]             res_len_r, res_len_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [BUF_AW-1:0]      out_pos_r, out_pos_nxt;
  logic [7:0]             out_len_r, out_len_nxt;

  logic                   in_acc;
  logic [LEN_W-1:0]       dlen, tlen;
  logic [CAP_W-1:0]       cap_eff;
  logic [BUF_AW:0]        tb_addr;
  logic [7:0]             tb_data, key_byte;
  logic [CAP_W:0]         div_r2;
  logic [LEN_W-1:0]       t_rem, d_rem, lim_full;
  logic [BUF_AW-1:0]      cand_w;

  logic                   dict_we, tgt_we, head_we, link_we;
  logic [HASH_AW-1:0]     head_waddr, head_wdata, head_rdata;
  logic [BUF_AW-1:0]      link_waddr;
  logic [HASH_AW-1:0]     link_wdata, link_rdata;
  logic [7:0]             dicta_rdata, dictb_rdata, tgt_rdata;

  // Configuration registers; the port never stalls.
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_len_r <= '0;
      tgt_len_r  <= '0;
      cap_r      <= CAP_W'(6144);
    end else if (cfg_if.valid) begin
      case (cfg_if.idx)
        CFG_DICT_LEN: dict_len_r <= cfg_if.data[LEN_W-1:0];
        CFG_TGT_LEN:  tgt_len_r  <= cfg_if.data[LEN_W-1:0];
        CFG_HASH_CAP: cap_r      <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign dlen    = (dict_len_r > LEN_W'(BUF_SIZE)) ? LEN_W'(BUF_SIZE) : dict_len_r;
  assign tlen    = (tgt_len_r > LEN_W'(BUF_SIZE)) ? LEN_W'(BUF_SIZE) : tgt_len_r;
  assign cap_eff = (cap_r == '0) ? CAP_W'(1) :
                   (cap_r > CAP_W'(HASH_SIZE)) ? CAP_W'(HASH_SIZE) : cap_r;

  assign in_if.ready     = (state_r == ST_IDLE);
  assign in_acc          = in_if.valid && in_if.ready;
  assign out_if.valid          = out_valid_r;
  assign out_if.match_position = out_pos_r;
  assign out_if.match_length   = out_len_r;

  // Address into the buffer that holds the key or target bytes.
  assign tb_addr  = {1'b0, pos_r} + ((state_r == ST_KEY) ? (BUF_AW+1)'(kcnt_r)
                                                         : (BUF_AW+1)'(cnt_r));
  assign tb_data  = in_dict_r ? dictb_rdata : tgt_rdata;
  assign key_byte = oob_r ? 8'd0 : tb_data;
  assign div_r2   = {rem_r, key_r[31]};

  assign cand_w   = BUF_AW'(entry_r - HASH_AW'(1));
  assign t_rem    = (tlen > LEN_W'(pos_r)) ? tlen - LEN_W'(pos_r) : '0;
  assign d_rem    = (dlen > LEN_W'(cand_w)) ? dlen - LEN_W'(cand_w) : '0;
  assign lim_full = (t_rem < d_rem) ? t_rem : d_rem;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    is_find_nxt   = is_find_r;
    pos_nxt       = pos_r;
    in_dict_nxt   = in_dict_r;
    kcnt_nxt      = kcnt_r;
    oob_nxt       = oob_r;
    key_nxt       = key_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    entry_nxt     = entry_r;
    steps_nxt     = steps_r;
    cand_nxt      = cand_r;
    lim_nxt       = lim_r;
    cnt_nxt       = cnt_r;
    best_pos_nxt  = best_pos_r;
    best_len_nxt  = best_len_r;
    res_pos_nxt   = res_pos_r;
    res_len_nxt   = res_len_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_pos_nxt   = out_pos_r;
    out_len_nxt   = out_len_r;
    dict_we       = 1'b0;
    tgt_we        = 1'b0;
    head_we       = 1'b0;
    head_waddr    = rem_r[HASH_AW-1:0];
    head_wdata    = HASH_AW'(pos_r) + HASH_AW'(1);
    link_we       = 1'b0;
    link_waddr    = pos_r;
    link_wdata    = head_rdata;

    case (state_r)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        head_wdata = '0;
        link_we    = (clr_r < HASH_AW'(BUF_SIZE));
        link_waddr = clr_r[BUF_AW-1:0];
        link_wdata = '0;
        clr_nxt    = clr_r + HASH_AW'(1);
        if (clr_r == HASH_AW'(HASH_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          pos_nxt      = in_if.position;
          in_dict_nxt  = in_if.target_in_dict;
          kcnt_nxt     = '0;
          best_pos_nxt = '0;
          best_len_nxt = '0;
          steps_nxt    = '0;
          res_pos_nxt  = '0;
          res_len_nxt  = '0;
          case (op_t'(in_if.opcode))
            OP_WR_DICT: begin
              dict_we   = 1'b1;
              state_nxt = ST_DONE;
            end
            OP_WR_TGT: begin
              tgt_we    = 1'b1;
              state_nxt = ST_DONE;
            end
            OP_INSERT: begin
              is_find_nxt = 1'b0;
              in_dict_nxt = 1'b1;
              state_nxt   = ST_KEY;
            end
            default: begin
              is_find_nxt = 1'b1;
              state_nxt   = (dlen == '0) ? ST_DONE : ST_KEY;
            end
          endcase
        end
      end
      ST_KEY: begin
        // Issue byte kcnt while collecting the byte before it from the registered read.
        oob_nxt  = tb_addr[BUF_AW];
        kcnt_nxt = kcnt_r + 3'd1;
        if (kcnt_r != 3'd0) begin
          key_nxt = {key_byte, key_r[31:8]};
        end
        if (kcnt_r == 3'd4) begin
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring remainder, one key bit per cycle, most significant first.
        if (div_r2 >= {1'b0, cap_eff}) begin
          rem_nxt = CAP_W'(div_r2 - {1'b0, cap_eff});
        end else begin
          rem_nxt = div_r2[CAP_W-1:0];
        end
        key_nxt  = {key_r[30:0], 1'b0};
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) begin
          state_nxt = ST_HEAD_RD;
        end
      end
      ST_HEAD_RD: begin
        state_nxt = ST_HEAD_WAIT;
      end
      ST_HEAD_WAIT: begin
        if (is_find_r) begin
          entry_nxt = head_rdata;
          state_nxt = ST_CAND;
        end else begin
          head_we   = 1'b1;
          link_we   = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_CAND: begin
        if (entry_r == '0 || steps_r == HASH_AW'(BUF_SIZE)) begin
          res_pos_nxt = best_pos_r;
          res_len_nxt = best_len_r;
          state_nxt   = ST_DONE;
        end else begin
          cand_nxt  = cand_w;
          steps_nxt = steps_r + HASH_AW'(1);
          lim_nxt   = (lim_full > LEN_W'(MAX_MATCH)) ? 8'(MAX_MATCH) : lim_full[7:0];
          cnt_nxt   = '0;
          state_nxt = ST_CMP_RD;
        end
      end
      ST_CMP_RD: begin
        state_nxt = (cnt_r == lim_r) ? ST_EVAL : ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        if (dicta_rdata == tb_data) begin
          cnt_nxt   = cnt_r + 8'd1;
          state_nxt = ST_CMP_RD;
        end else begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // Only a strictly longer match wins, so the nearest one keeps a tie.
        if (cnt_r > best_len_r) begin
          best_len_nxt = cnt_r;
          best_pos_nxt = cand_r;
        end
        state_nxt = ST_LINK_WAIT;
      end
      ST_LINK_WAIT: begin
        entry_nxt = link_rdata;
        state_nxt = ST_CAND;
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = res_pos_r;
          out_len_nxt   = res_len_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_find_r  <= is_find_nxt;
    pos_r      <= pos_nxt;
    in_dict_r  <= in_dict_nxt;
    kcnt_r     <= kcnt_nxt;
    oob_r      <= oob_nxt;
    key_r      <= key_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    entry_r    <= entry_nxt;
    steps_r    <= steps_nxt;
    cand_r     <= cand_nxt;
    lim_r      <= lim_nxt;
    cnt_r      <= cnt_nxt;
    best_pos_r <= best_pos_nxt;
    best_len_r <= best_len_nxt;
    res_pos_r  <= res_pos_nxt;
    res_len_r  <= res_len_nxt;
    out_pos_r  <= out_pos_nxt;
    out_len_r  <= out_len_nxt;
  end

  // Two copies of the dictionary: one for candidate bytes, one for target bytes.
  lzhc_ram #(.WIDTH(8), .DEPTH(BUF_SIZE)) u_dict_a (
    .clk(clk), .we(dict_we), .waddr(in_if.position), .wdata(in_if.data_byte),
    .raddr(BUF_AW'(cand_r + BUF_AW'(cnt_r))), .rdata(dicta_rdata)
  );

  lzhc_ram #(.WIDTH(8), .DEPTH(BUF_SIZE)) u_dict_b (
    .clk(clk), .we(dict_we), .waddr(in_if.position), .wdata(in_if.data_byte),
    .raddr(tb_addr[BUF_AW-1:0]), .rdata(dictb_rdata)
  );

  lzhc_ram #(.WIDTH(8), .DEPTH(BUF_SIZE)) u_tgt (
    .clk(clk), .we(tgt_we), .waddr(in_if.position), .wdata(in_if.data_byte),
    .raddr(tb_addr[BUF_AW-1:0]), .rdata(tgt_rdata)
  );

  lzhc_ram #(.WIDTH(HASH_AW), .DEPTH(HASH_SIZE)) u_heads (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(rem_r[HASH_AW-1:0]), .rdata(head_rdata)
  );

  lzhc_ram #(.WIDTH(HASH_AW), .DEPTH(BUF_SIZE)) u_links (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(cand_r), .rdata(link_rdata)
  );

endmodule

@@ src/lzhc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lzhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
